// ----- src/tbp_pkg.sv -----
// ----------------------------------------------------------------------------
// tbp_pkg: tournament branch predictor shared definitions
// Table sizes, field types and the saturating 2-bit counter step.
// ----------------------------------------------------------------------------
package tbp_pkg;

  localparam int GHIST_BITS    = 9;
  localparam int LHIST_BITS    = 10;
  localparam int PC_INDEX_BITS = 10;

  // widest table index; the clearing sweep walks this many bits
  localparam int CLR_BITS_LG = (LHIST_BITS > GHIST_BITS) ? LHIST_BITS : GHIST_BITS;
  localparam int CLR_BITS    = (PC_INDEX_BITS > CLR_BITS_LG) ? PC_INDEX_BITS : CLR_BITS_LG;

  localparam int PC_W        = 32;
  localparam int IN_TDATA_W  = 40;  // pc + outcome, padded to whole bytes
  localparam int OUT_TDATA_W = 8;

  typedef logic [GHIST_BITS-1:0]    ghist_t;
  typedef logic [LHIST_BITS-1:0]    lhist_t;
  typedef logic [PC_INDEX_BITS-1:0] pidx_t;
  typedef logic [CLR_BITS-1:0]      clr_cnt_t;
  typedef logic [1:0]               ctr_t;

  localparam ctr_t CTR_INIT = 2'd1;  // weakly not taken / favour local
  localparam ctr_t CTR_MAX  = 2'd3;
  localparam ctr_t CTR_MIN  = 2'd0;

  localparam logic ACT_PREDICT = 1'b0;
  localparam logic ACT_TRAIN   = 1'b1;

  function automatic ctr_t sat_move(input ctr_t c, input logic up);
    ctr_t r;
    if (up) begin
      r = (c == CTR_MAX) ? CTR_MAX : ctr_t'(c + 2'd1);
    end else begin
      r = (c == CTR_MIN) ? CTR_MIN : ctr_t'(c - 2'd1);
    end
    return r;
  endfunction

endpackage

// ----- src/tournament_branch_predictor.sv -----
// ----------------------------------------------------------------------------
// tournament_branch_predictor: local/global tournament predictor
// Predict and train requests in, one prediction out per request.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one request per transfer. in_tuser = action (0 predict, 1 train),
//           in_tdata = pc (bits 31:0), outcome (bit 32).
//   out_* : one result per request, in order. out_tdata bit 0 = predicted_taken,
//           taken from the tables as they stood before that request's update.
//   Throughput: one request per cycle outside the clearing sweep and output
//   stalls. The depth is set by the two chained table reads (local history,
//   then the counter tables), each with registered read data, followed by
//   the result register. Same-address hazards between requests in flight
//   are resolved by write bypass registers.
//   Reset: a clearing sweep over 2**CLR_BITS addresses (1024 with the default
//   sizes) loads the history table with zeros and all counters with 1;
//   in_tready stays low until it completes.
//   Stall: while out_tready is low the result register holds; earlier stages
//   advance until stage 2 is full, then all stages hold and in_tready drops.
// ----------------------------------------------------------------------------
module tournament_branch_predictor (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [tbp_pkg::IN_TDATA_W-1:0] in_tdata,   // [31:0] pc, [32] outcome
  input  logic                           in_tuser,   // [0] action
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [tbp_pkg::OUT_TDATA_W-1:0] out_tdata  // [0] predicted_taken
);
  import tbp_pkg::*;

  typedef struct packed {
    pidx_t  pidx;
    ghist_t gidx;
    logic   train;
    logic   taken;
  } s1_t;

  typedef struct packed {
    lhist_t lhist;
    ghist_t gidx;
    logic   train;
    logic   taken;
  } s2_t;

  // tables
  lhist_t lht_mem [2**PC_INDEX_BITS];
  ctr_t   lc_mem  [2**LHIST_BITS];
  ctr_t   gc_mem  [2**GHIST_BITS];
  ctr_t   ch_mem  [2**GHIST_BITS];

  logic     clr_r;
  clr_cnt_t clr_cnt_r;

  ghist_t ghist_r, ghist_nxt;

  logic   s1_v_r, s2_v_r, out_v_r;
  s1_t    s1_r, s1_nxt;
  s2_t    s2_r, s2_nxt;
  logic   out_pred_r;

  lhist_t lht_rd_r;
  ctr_t   lc_rd_r, gc_rd_r, ch_rd_r;

  // bypass of the write made at the same edge as the read
  logic   lhw_v_r;
  pidx_t  lhw_a_r;
  lhist_t lhw_d_r;
  logic   lcw_v_r;
  lhist_t lcw_a_r;
  ctr_t   lcw_d_r;
  logic   gw_v_r;
  ghist_t gw_a_r;
  ctr_t   gcw_d_r, chw_d_r;

  logic   adv, in_acc;
  lhist_t lhist_eff;
  ctr_t   lc_eff, gc_eff, ch_eff;
  logic   lpred, gpred, pred;
  ctr_t   lc_new, gc_new, ch_new;
  lhist_t lh_new;

  logic   lht_we, lc_we, gc_we;
  pidx_t  lht_wa;
  lhist_t lht_wd, lc_wa;
  ghist_t gc_wa;
  ctr_t   lc_wd, gc_wd, ch_wd;

  assign adv       = !(out_v_r && !out_tready && s2_v_r);
  assign in_tready = !clr_r && adv;
  assign in_acc    = in_tvalid && in_tready;

  // stage 0: incoming request feeds history table read
  always_comb begin
    ghist_nxt = ghist_r;
    if (in_acc && in_tuser == ACT_TRAIN) begin
      ghist_nxt = ghist_t'({ghist_r, in_tdata[PC_W]});
    end
    s1_nxt.pidx  = in_tdata[PC_INDEX_BITS-1:0];
    s1_nxt.gidx  = ghist_r;
    s1_nxt.train = (in_tuser == ACT_TRAIN);
    s1_nxt.taken = in_tdata[PC_W];
  end

  // stage 1: local history with bypass, feeds counter reads
  always_comb begin
    lhist_eff = (lhw_v_r && lhw_a_r == s1_r.pidx) ? lhw_d_r : lht_rd_r;
    lh_new    = lhist_t'({lhist_eff, s1_r.taken});
    s2_nxt.lhist = lhist_eff;
    s2_nxt.gidx  = s1_r.gidx;
    s2_nxt.train = s1_r.train;
    s2_nxt.taken = s1_r.taken;
  end

  // stage 2: counters with bypass, prediction and update
  always_comb begin
    lc_eff = (lcw_v_r && lcw_a_r == s2_r.lhist) ? lcw_d_r : lc_rd_r;
    gc_eff = (gw_v_r && gw_a_r == s2_r.gidx) ? gcw_d_r : gc_rd_r;
    ch_eff = (gw_v_r && gw_a_r == s2_r.gidx) ? chw_d_r : ch_rd_r;
    lpred  = lc_eff[1];
    gpred  = gc_eff[1];
    pred   = ch_eff[1] ? gpred : lpred;
    lc_new = sat_move(lc_eff, s2_r.taken);
    gc_new = sat_move(gc_eff, s2_r.taken);
    ch_new = (lpred != gpred) ? sat_move(ch_eff, gpred == s2_r.taken) : ch_eff;
  end

  // write ports: clearing sweep or normal update
  always_comb begin
    if (clr_r) begin
      lht_we = 1'b1;
      lht_wa = clr_cnt_r[PC_INDEX_BITS-1:0];
      lht_wd = '0;
      lc_we  = 1'b1;
      lc_wa  = clr_cnt_r[LHIST_BITS-1:0];
      lc_wd  = CTR_INIT;
      gc_we  = 1'b1;
      gc_wa  = clr_cnt_r[GHIST_BITS-1:0];
      gc_wd  = CTR_INIT;
      ch_wd  = CTR_INIT;
    end else begin
      lht_we = adv && s1_v_r && s1_r.train;
      lht_wa = s1_r.pidx;
      lht_wd = lh_new;
      lc_we  = adv && s2_v_r && s2_r.train;
      lc_wa  = s2_r.lhist;
      lc_wd  = lc_new;
      gc_we  = adv && s2_v_r && s2_r.train;
      gc_wa  = s2_r.gidx;
      gc_wd  = gc_new;
      ch_wd  = ch_new;
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (lht_we) begin
      lht_mem[lht_wa] <= lht_wd;
    end
    if (adv) begin
      lht_rd_r <= lht_mem[s1_nxt.pidx];
    end
  end

  always_ff @(posedge clk) begin
    if (lc_we) begin
      lc_mem[lc_wa] <= lc_wd;
    end
    if (adv) begin
      lc_rd_r <= lc_mem[lhist_eff];
    end
  end

  always_ff @(posedge clk) begin
    if (gc_we) begin
      gc_mem[gc_wa] <= gc_wd;
    end
    if (adv) begin
      gc_rd_r <= gc_mem[s1_r.gidx];
    end
  end

  always_ff @(posedge clk) begin
    if (gc_we) begin
      ch_mem[gc_wa] <= ch_wd;
    end
    if (adv) begin
      ch_rd_r <= ch_mem[s1_r.gidx];
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_cnt_r <= '0;
      ghist_r   <= '0;
      s1_v_r    <= 1'b0;
      s2_v_r    <= 1'b0;
      out_v_r   <= 1'b0;
      lhw_v_r   <= 1'b0;
      lcw_v_r   <= 1'b0;
      gw_v_r    <= 1'b0;
    end else begin
      if (clr_r) begin
        clr_cnt_r <= clr_cnt_t'(clr_cnt_r + 1'b1);
        if (&clr_cnt_r) begin
          clr_r <= 1'b0;
        end
      end
      ghist_r <= ghist_nxt;
      if (adv) begin
        s1_v_r  <= in_acc;
        s2_v_r  <= s1_v_r;
        lhw_v_r <= lht_we && !clr_r;
        lcw_v_r <= lc_we && !clr_r;
        gw_v_r  <= gc_we && !clr_r;
      end
      if (!out_v_r || out_tready) begin
        out_v_r <= s2_v_r;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r    <= s1_nxt;
      s2_r    <= s2_nxt;
      lhw_a_r <= lht_wa;
      lhw_d_r <= lht_wd;
      lcw_a_r <= lc_wa;
      lcw_d_r <= lc_wd;
      gw_a_r  <= gc_wa;
      gcw_d_r <= gc_wd;
      chw_d_r <= ch_wd;
    end
    if (!out_v_r || out_tready) begin
      out_pred_r <= pred;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {{(OUT_TDATA_W-1){1'b0}}, out_pred_r};

`ifndef SYNTHESIS
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_r |-> !in_tready)
    else $error("request taken during clearing sweep");

  a_accept_enters_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> s1_v_r)
    else $error("accepted request not in stage 1");

  a_s2_held_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_tready && s2_v_r |=> s2_v_r && $stable(s2_r))
    else $error("stage 2 lost during output stall");

  a_ghist_only_on_train: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tvalid && in_tready && in_tuser == ACT_TRAIN) |=> $stable(ghist_r))
    else $error("global history moved without a train request");
`endif

endmodule

// ----- tb/tournament_branch_predictor_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tournament_branch_predictor_tb: self-checking bench for the predictor
// Streams predict and train requests with random gaps on both sides, keeps
// its own copy of the history and counter tables, and checks every
// prediction in order against it.
// ----------------------------------------------------------------------------
module tournament_branch_predictor_tb;

  import tbp_pkg::*;

  localparam int PIDX_ENTRIES  = 1 << PC_INDEX_BITS;
  localparam int LOCAL_ENTRIES = 1 << LHIST_BITS;
  localparam int GLOB_ENTRIES  = 1 << GHIST_BITS;
  localparam int N_SLOTS       = 8;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // [31:0] pc, [32] outcome
  logic                   in_tuser;   // [0] action
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // [0] predicted_taken

  tournament_branch_predictor dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // shadow copy of the predictor tables
  lhist_t hist_tab   [PIDX_ENTRIES];
  ctr_t   local_ctr  [LOCAL_ENTRIES];
  ctr_t   glob_ctr   [GLOB_ENTRIES];
  ctr_t   choose_ctr [GLOB_ENTRIES];
  ghist_t ghist;

  logic   pred_q[$];
  int     err_count;
  int     n_train;
  int     n_predict;
  int     n_checked;
  int     n_choose;
  logic   steady;  // suppresses idling on both sides while set

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic ctr_t ctr_nudge(input ctr_t c, input logic up);
    if (up) begin
      return (&c) ? c : ctr_t'(c + 2'd1);
    end
    return (|c) ? ctr_t'(c - 2'd1) : c;
  endfunction

  function automatic void clear_tables();
    ghist = '0;
    foreach (hist_tab[i])   hist_tab[i]   = '0;
    foreach (local_ctr[i])  local_ctr[i]  = CTR_INIT;
    foreach (glob_ctr[i])   glob_ctr[i]   = CTR_INIT;
    foreach (choose_ctr[i]) choose_ctr[i] = CTR_INIT;
  endfunction

  // prediction from the current tables, then the training update if asked
  function automatic logic predict_and_train(input logic act, input logic [PC_W-1:0] pc,
                                             input logic taken);
    pidx_t  idx;
    lhist_t lh;
    ghist_t gidx;
    ctr_t   lc;
    ctr_t   gc;
    ctr_t   ch;
    logic   lp;
    logic   gp;
    logic   pred;
    idx  = pc[PC_INDEX_BITS-1:0];
    lh   = hist_tab[idx];
    gidx = ghist;
    lc   = local_ctr[lh];
    gc   = glob_ctr[gidx];
    ch   = choose_ctr[gidx];
    lp   = lc[1];
    gp   = gc[1];
    pred = ch[1] ? gp : lp;
    if (act == ACT_TRAIN) begin
      if (lp != gp) begin
        choose_ctr[gidx] = ctr_nudge(ch, gp == taken);
        n_choose++;
      end
      local_ctr[lh]  = ctr_nudge(lc, taken);
      glob_ctr[gidx] = ctr_nudge(gc, taken);
      hist_tab[idx]  = lhist_t'({lh, taken});
      ghist          = ghist_t'({gidx, taken});
    end
    return pred;
  endfunction

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // one request; valid is only lowered when a gap precedes it
  task automatic send_request(input logic act, input logic [PC_W-1:0] pc, input logic taken);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {{(IN_TDATA_W-PC_W-1){1'b0}}, taken, pc};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pred_q.push_back(predict_and_train(act, pc, taken));
    if (act == ACT_TRAIN) n_train++;
    else n_predict++;
  endtask

  // result side: random stalls, with steady stretches
  initial begin
    out_tready = 1'b0;
    forever begin
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      if (!steady && $urandom_range(0, 2) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(0, 9) == 0 ? $urandom_range(8, 30) : $urandom_range(1, 3))
          @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pred_q.size() == 0) begin
        $error("result with no request outstanding: predicted_taken %0b", out_tdata[0]);
        err_count++;
      end else begin
        logic want;
        want = pred_q.pop_front();
        n_checked++;
        if (out_tdata[0] !== want) begin
          $error("predicted_taken mismatch: expected %0b, got %0b", want, out_tdata[0]);
          err_count++;
        end
      end
    end
  end

  // cold tables at both address extremes; outcome must be ignored
  task automatic test_cold_predict();
    send_request(ACT_PREDICT, 32'h0000_0000, 1'b1);
    send_request(ACT_PREDICT, 32'hFFFF_FFFF, 1'b0);
    send_request(ACT_PREDICT, 32'hFFFF_FFFF, 1'b1);
  endtask

  // long taken run fills both histories with ones, stepping the counters it meets,
  // then a not-taken run on an aliasing pc drives both histories back to zero
  task automatic test_saturation();
    for (int i = 0; i < 10; i++) send_request(ACT_TRAIN, 32'h0000_0404, 1'b1);
    send_request(ACT_PREDICT, 32'h0000_0404, 1'b0);
    for (int i = 0; i < 10; i++) send_request(ACT_TRAIN, 32'hFFFF_FC04, 1'b0);
  endtask

  // loop-like branches: taken period-1 times, then one not taken
  task automatic test_loop_patterns(input int count);
    logic [PC_W-1:0] slot_pc  [N_SLOTS];
    int              slot_len [N_SLOTS];
    int              slot_pos [N_SLOTS];
    int              s;
    logic            taken;
    for (int k = 0; k < N_SLOTS; k++) begin
      slot_pc[k]  = $urandom();
      slot_len[k] = $urandom_range(2, 12);
      slot_pos[k] = 0;
    end
    for (int i = 0; i < count; i++) begin
      steady = ((i % 100) >= 65);
      s      = $urandom_range(0, N_SLOTS - 1);
      taken  = (slot_pos[s] != slot_len[s] - 1);
      if ($urandom_range(0, 9) == 0) begin
        send_request(ACT_PREDICT, slot_pc[s], 1'($urandom_range(0, 1)));
      end else begin
        send_request(ACT_TRAIN, slot_pc[s], taken);
        slot_pos[s] = (slot_pos[s] + 1) % slot_len[s];
      end
      // occasionally swap a branch for a fresh one
      if ($urandom_range(0, 63) == 0) begin
        slot_pc[s]  = $urandom();
        slot_len[s] = $urandom_range(2, 12);
        slot_pos[s] = 0;
      end
    end
    steady = 1'b0;
  endtask

  // noise: random addresses, many sharing low index bits with others
  task automatic test_random_traffic(input int count);
    logic [PC_W-1:0] pc;
    for (int i = 0; i < count; i++) begin
      steady = ((i % 80) < 20);
      pc = $urandom();
      if ($urandom_range(0, 1) == 0) pc[PC_INDEX_BITS-1:0] = pidx_t'($urandom_range(0, 3));
      send_request($urandom_range(0, 3) != 0 ? ACT_TRAIN : ACT_PREDICT, pc,
                   1'($urandom_range(0, 1)));
    end
    steady = 1'b0;
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = ACT_PREDICT;
    err_count = 0;
    n_train   = 0;
    n_predict = 0;
    n_checked = 0;
    n_choose  = 0;
    steady    = 1'b0;
    clear_tables();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_cold_predict();
    test_saturation();
    test_loop_patterns(540);
    test_random_traffic(300);
    in_tvalid <= 1'b0;

    while (pred_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d requests (%0d train, %0d predict-only), checked %0d predictions.",
             n_train + n_predict, n_train, n_predict, n_checked);
    $display("Chooser nudged %0d times over loop patterns, saturation runs and aliased noise.",
             n_choose);
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

// ----- filelist.f -----
src/tbp_pkg.sv
src/tournament_branch_predictor.sv
tb/tournament_branch_predictor_tb.sv
